/* src/fullwidth_halfwidth_converter_macros.svh */
// ----------------------------------------------------------------------------
// Fullwidth/halfwidth converter assertion macros
// Shared concurrent assertion forms for the converter modules.
// ----------------------------------------------------------------------------
`ifndef FULLWIDTH_HALFWIDTH_CONVERTER_MACROS_SVH
`define FULLWIDTH_HALFWIDTH_CONVERTER_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define FWHW_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwhw: implication check failed");

// Antecedent implies consequent in the following cycle, outside reset.
`define FWHW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwhw: next-cycle check failed");

`endif

/* src/fwhw_pkg.sv */
// ----------------------------------------------------------------------------
// fwhw_pkg
// Types and constants for the fullwidth/halfwidth UTF-8 converter.
// ----------------------------------------------------------------------------
package fwhw_pkg;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_LEAD = 2'd1,
    HELD_BOTH = 2'd2
  } held_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;
    logic       string_end;
  } result_t;

  localparam logic [1:0]  CNT_ONE   = 2'd1;
  localparam logic [1:0]  CNT_TWO   = 2'd2;
  localparam logic [1:0]  CNT_THREE = 2'd3;

  localparam logic        DIR_FULL_TO_HALF = 1'b0;

  localparam logic [15:0] CP_IDEO_SPACE = 16'h3000;
  localparam logic [15:0] CP_FULL_LO    = 16'hFF01;
  localparam logic [15:0] CP_FULL_HI    = 16'hFF5E;
  localparam logic [15:0] FULL_OFFSET   = 16'hFEE0;

  localparam logic [7:0]  ASCII_SPACE = 8'h20;
  localparam logic [7:0]  ASCII_LO    = 8'h21;
  localparam logic [7:0]  ASCII_HI    = 8'h7E;

  localparam logic [3:0]  LEAD3_NIBBLE = 4'hE;
  localparam logic [1:0]  CONT_PREFIX  = 2'b10;

endpackage

/* src/fwhw_conv.sv */
// ----------------------------------------------------------------------------
// fwhw_conv
// Input register, group buffer and conversion logic for one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module fwhw_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_string,
  output logic                res_valid,
  input  logic                res_ready,
  output fwhw_pkg::result_t   res
);

  `include "fullwidth_halfwidth_converter_macros.svh"

  logic                direction_r;
  logic                s1_valid_r, s1_valid_nxt;
  logic [7:0]          s1_byte_r;
  logic                s1_eos_r;
  fwhw_pkg::held_t     held_r, held_nxt;
  logic [7:0]          lead_r, lead_nxt;
  logic [7:0]          second_r, second_nxt;

  logic                emit;
  logic                s1_consume;
  logic                in_take;
  logic [15:0]         cp_full;
  logic [15:0]         cp_grp;
  logic [7:0]          cp_ascii;

  // Three-byte UTF-8 form of a 16-bit code point
  function automatic logic [23:0] encode3(input logic [15:0] cp);
    encode3 = {fwhw_pkg::LEAD3_NIBBLE, cp[15:12],
               fwhw_pkg::CONT_PREFIX, cp[11:6],
               fwhw_pkg::CONT_PREFIX, cp[5:0]};
  endfunction

  assign cp_full  = {8'h00, s1_byte_r} + fwhw_pkg::FULL_OFFSET;
  assign cp_grp   = {lead_r[3:0], second_r[5:0], s1_byte_r[5:0]};
  assign cp_ascii = 8'(cp_grp - fwhw_pkg::FULL_OFFSET);

  always_comb begin
    emit       = 1'b1;
    held_nxt   = held_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    res        = '0;
    res.b0     = s1_byte_r;
    res.count  = fwhw_pkg::CNT_ONE;
    res.string_end = s1_eos_r;
    if (direction_r != fwhw_pkg::DIR_FULL_TO_HALF) begin
      if (s1_byte_r >= fwhw_pkg::ASCII_LO && s1_byte_r <= fwhw_pkg::ASCII_HI) begin
        {res.b0, res.b1, res.b2} = encode3(cp_full);
        res.count = fwhw_pkg::CNT_THREE;
      end else if (s1_byte_r == fwhw_pkg::ASCII_SPACE) begin
        {res.b0, res.b1, res.b2} = encode3(fwhw_pkg::CP_IDEO_SPACE);
        res.count = fwhw_pkg::CNT_THREE;
      end
    end else begin
      case (held_r)
        fwhw_pkg::HELD_NONE: begin
          if (s1_byte_r[7:4] == fwhw_pkg::LEAD3_NIBBLE && !s1_eos_r) begin
            emit     = 1'b0;
            held_nxt = fwhw_pkg::HELD_LEAD;
            lead_nxt = s1_byte_r;
          end
        end
        fwhw_pkg::HELD_LEAD: begin
          if (s1_eos_r) begin
            // flush the partial group as it stands
            res.b0    = lead_r;
            res.b1    = s1_byte_r;
            res.count = fwhw_pkg::CNT_TWO;
            held_nxt  = fwhw_pkg::HELD_NONE;
          end else begin
            emit       = 1'b0;
            held_nxt   = fwhw_pkg::HELD_BOTH;
            second_nxt = s1_byte_r;
          end
        end
        fwhw_pkg::HELD_BOTH: begin
          held_nxt = fwhw_pkg::HELD_NONE;
          if (cp_grp == fwhw_pkg::CP_IDEO_SPACE) begin
            res.b0 = fwhw_pkg::ASCII_SPACE;
          end else if (cp_grp >= fwhw_pkg::CP_FULL_LO && cp_grp <= fwhw_pkg::CP_FULL_HI) begin
            res.b0 = cp_ascii;
          end else begin
            res.b0    = lead_r;
            res.b1    = second_r;
            res.b2    = s1_byte_r;
            res.count = fwhw_pkg::CNT_THREE;
          end
        end
        default: begin
          held_nxt = fwhw_pkg::HELD_NONE;
        end
      endcase
    end
  end

  assign res_valid    = s1_valid_r && emit;
  assign s1_consume   = s1_valid_r && (!emit || res_ready);
  assign in_stall     = s1_valid_r && !s1_consume;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take ? 1'b1 : (s1_consume ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= fwhw_pkg::DIR_FULL_TO_HALF;
      s1_valid_r  <= 1'b0;
      held_r      <= fwhw_pkg::HELD_NONE;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        // a direction write drops any partial group
        direction_r <= cfg_wdata;
        held_r      <= fwhw_pkg::HELD_NONE;
      end else if (s1_consume) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
      s1_eos_r  <= in_end_of_string;
    end
    if (s1_consume) begin
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
    end
  end

  `FWHW_ASSERT_IMPLY(a_h2f_holds_nothing, clk, rst_n,
    direction_r != fwhw_pkg::DIR_FULL_TO_HALF, held_r == fwhw_pkg::HELD_NONE)
  `FWHW_ASSERT_NEXT(a_eos_empties_buffer, clk, rst_n,
    s1_consume && s1_eos_r && !cfg_we, held_r == fwhw_pkg::HELD_NONE)

endmodule

/* src/fwhw_outreg.sv */
// ----------------------------------------------------------------------------
// fwhw_outreg
// Result register: holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module fwhw_outreg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  output logic                res_ready,
  input  fwhw_pkg::result_t   res,
  output logic                out_valid,
  input  logic                out_stall,
  output fwhw_pkg::result_t   out_res
);

  `include "fullwidth_halfwidth_converter_macros.svh"

  logic              out_valid_r, out_valid_nxt;
  fwhw_pkg::result_t res_r;
  logic              load;

  assign res_ready     = !out_valid_r || !out_stall;
  assign load          = res_valid && res_ready;
  assign out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  `FWHW_ASSERT_IMPLY(a_count_nonzero, clk, rst_n,
    out_valid_r, res_r.count != 2'd0)
  `FWHW_ASSERT_IMPLY(a_two_byte_is_flush, clk, rst_n,
    out_valid_r && res_r.count == fwhw_pkg::CNT_TWO, res_r.string_end)

endmodule

/* src/fullwidth_halfwidth_converter.sv */
// Accepted bytes pass the input register, then the conversion, then the result register.
// Throughput: one byte per cycle; with the result register full, out_stall holds the
// input in the same cycle.
// Full-to-half: a held lead or second byte gives no result unless it ends the string.
// Reset (rst_n low, synchronous) clears both valid stages and the group buffer,
// and sets the direction to fullwidth-to-halfwidth.
// ----------------------------------------------------------------------------
// fullwidth_halfwidth_converter
// UTF-8 fullwidth/halfwidth converter, direction selected by a register.
// ----------------------------------------------------------------------------
module fullwidth_halfwidth_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [1:0] out_count,
  output logic       out_string_end
);

  logic              res_valid;
  logic              res_ready;
  fwhw_pkg::result_t res;
  fwhw_pkg::result_t out_res;

  fwhw_conv u_conv (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  fwhw_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte0      = out_res.b0;
  assign out_byte1      = out_res.b1;
  assign out_byte2      = out_res.b2;
  assign out_count      = out_res.count;
  assign out_string_end = out_res.string_end;

endmodule
